FILE: src/mrh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrh_pkg
// Types, constants and step tables for the modified RIPEMD-128 hash block.
// ----------------------------------------------------------------------------
package mrh_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CNT_W       = 61;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_FOLD,
        S_EMIT
    } t_back_state;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD1,
        SRC_PAD2
    } t_word_src;

    localparam logic [31:0] IV0 = 32'h10257436;
    localparam logic [31:0] IV1 = 32'ha8bd9cfe;
    localparam logic [31:0] IV2 = 32'h9efcad8b;
    localparam logic [31:0] IV3 = 32'h12375460;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;

    localparam logic [3:0] K_WIDX [0:127] = '{
        0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
        7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
        3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
        1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
        5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
        6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
        15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
        8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14
    };

    localparam logic [3:0] K_WROT [0:127] = '{
        11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
        7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
        11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
        11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
        8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
        9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
        9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
        15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8
    };

    function automatic logic [31:0] f_step_k(input logic [6:0] s);
        logic [31:0] k;
        unique case (s[6:4])
            3'd0:    k = 32'h00000002;
            3'd1:    k = 32'h325b99a1;
            3'd2:    k = 32'h1baed69c;
            3'd3:    k = 32'hbcdcb1f9;
            3'd4:    k = 32'h5a82798a;
            3'd5:    k = 32'h41d42d5d;
            3'd6:    k = 32'h30ed3f68;
            default: k = 32'h00000002;
        endcase
        case (s)
            7'd17, 7'd25, 7'd31, 7'd59:         k = 32'h00000002;
            7'd23, 7'd74, 7'd86:                k = 32'hbcdcb1f9;
            7'd43, 7'd50, 7'd70, 7'd94:         k = 32'h325b99a1;
            7'd45:                              k = 32'hbcdcb1fa;
            7'd53:                              k = 32'hbcdcb1fb;
            7'd57:                              k = 32'h1baed69c;
            7'd63, 7'd78:                       k = 32'hbcdcb1fc;
            7'd87:                              k = 32'hbcdcb1fd;
            7'd102, 7'd113:                     k = 32'hbcdcb1fe;
            7'd105:                             k = 32'h5a82798a;
            7'd110:                             k = 32'h41d42d5d;
            default:                            k = k;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] f_bool(input logic [2:0] rd, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
        logic [31:0] r;
        case (rd)
            3'd0, 3'd7: r = x ^ y ^ z;
            3'd1, 3'd6: r = (x & y) | (~x & z);
            3'd2, 3'd5: r = (x | ~y) ^ z;
            default:    r = (x & z) | (y & ~z);
        endcase
        return r;
    endfunction

endpackage

FILE: src/mrh_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrh_front
// Input side: takes items into a short queue that the engine drains.
// ----------------------------------------------------------------------------
module mrh_front
    import mrh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_q_valid,
    output t_in_item      o_q_item,
    input  wire logic     i_q_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_in_item           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [PTR_W:0]     r_cnt;
    logic               push;

    assign o_in_stall = (r_cnt == (PTR_W+1)'(DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_in_item;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PTR_W+1)'(push) - (PTR_W+1)'(i_q_pop);
        end
    end

endmodule
`default_nettype wire

FILE: src/mrh_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrh_back
// Engine: block gather, padding, one compression step a cycle, digest output.
// ----------------------------------------------------------------------------
module mrh_back
    import mrh_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_q_valid,
    input  wire t_in_item i_q_item,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    t_back_state        r_state, n_state;
    t_word_src          r_src, n_src;
    logic [31:0]        r_w [16];
    logic [31:0]        r_v [8];
    logic [31:0]        n_v [8];
    logic [31:0]        r_cv [4];
    logic [31:0]        n_cv [4];
    logic [CNT_W-1:0]   r_count, n_count;
    logic [6:0]         r_step, n_step;
    logic               r_last_pend, n_last_pend;
    logic [1:0]         r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    logic               wr_byte;
    logic [5:0]         pos;
    logic [3:0]         wi;
    logic [31:0]        word, raw, step_sum;
    logic [63:0]        rot_tmp;
    logic [2:0]         ia, ib, ic, id;
    logic [1:0]         la;
    logic               with_len;

    assign pos      = r_count[5:0];
    assign wi       = K_WIDX[r_step];
    assign raw      = r_w[wi];
    assign with_len = (r_src == SRC_PAD2) || (r_src == SRC_PAD1 && pos < LEN_POS);

    always_comb begin
        word = raw;
        if (r_src != SRC_DATA) begin
            for (int j = 0; j < 4; j++) begin
                if (r_src == SRC_PAD2 || {wi, 2'(j)} > pos) begin
                    word[8*j +: 8] = '0;
                end else if ({wi, 2'(j)} == pos) begin
                    word[8*j +: 8] = PAD_BYTE;
                end
            end
            if (with_len && wi == 4'd14) begin
                word = {r_count[28:0], 3'b000};
            end else if (with_len && wi == 4'd15) begin
                word = r_count[60:29];
            end
        end
    end

    assign la = 2'(2'd0 - r_step[1:0]);
    assign ia = {r_step[6], la};
    assign ib = {r_step[6], 2'(la + 2'd1)};
    assign ic = {r_step[6], 2'(la + 2'd2)};
    assign id = {r_step[6], 2'(la + 2'd3)};
    assign step_sum = r_v[ia] + f_bool(r_step[6:4], r_v[ib], r_v[ic], r_v[id])
                      + word + f_step_k(r_step);
    assign rot_tmp  = {step_sum, step_sum} << K_WROT[r_step];

    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        n_v         = r_v;
        n_cv        = r_cv;
        n_count     = r_count;
        n_step      = r_step;
        n_last_pend = r_last_pend;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_q_pop     = 1'b0;
        wr_byte     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop     = 1'b1;
                    n_last_pend = i_q_item.last;
                    n_step      = '0;
                    for (int i = 0; i < 8; i++) n_v[i] = r_cv[i % 4];
                    if (i_q_item.has_byte) begin
                        wr_byte = 1'b1;
                        n_count = r_count + 1'b1;
                        if (pos == 6'd63) begin
                            n_src   = SRC_DATA;
                            n_state = S_STEP;
                        end else if (i_q_item.last) begin
                            n_src   = SRC_PAD1;
                            n_state = S_STEP;
                        end
                    end else if (i_q_item.last) begin
                        n_src   = SRC_PAD1;
                        n_state = S_STEP;
                    end
                end
            end
            S_STEP: begin
                n_v[ia] = rot_tmp[63:32];
                n_step  = r_step + 1'b1;
                if (r_step == 7'd127) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_cv[0] = r_v[7] + r_v[2] + r_cv[1];
                n_cv[1] = r_cv[2] + r_v[3] + r_v[4];
                n_cv[2] = r_cv[3] + r_v[0] + r_v[5] + 32'd1;
                n_cv[3] = r_cv[0] + r_v[1] + r_v[6];
                n_step  = '0;
                for (int i = 0; i < 8; i++) n_v[i] = n_cv[i % 4];
                n_idx   = '0;
                unique case (r_src)
                    SRC_DATA: begin
                        n_src   = SRC_PAD1;
                        n_state = r_last_pend ? S_STEP : S_IDLE;
                    end
                    SRC_PAD1: begin
                        n_src   = SRC_PAD2;
                        n_state = (pos >= LEN_POS) ? S_STEP : S_EMIT;
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.digest_word = r_cv[r_idx];
                    n_out.word_index  = r_idx;
                    n_out.last_word   = (r_idx == 2'd3);
                    n_idx             = r_idx + 1'b1;
                    if (r_idx == 2'd3) begin
                        n_cv    = '{IV0, IV1, IV2, IV3};
                        n_count = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_byte) begin
            r_w[pos[5:2]][8*pos[1:0] +: 8] <= i_q_item.data_byte;
        end
        r_v         <= n_v;
        r_out       <= n_out;
        r_step      <= n_step;
        r_src       <= n_src;
        r_last_pend <= n_last_pend;
        r_idx       <= n_idx;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cv        <= '{IV0, IV1, IV2, IV3};
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cv        <= n_cv;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

FILE: src/modified_ripemd128_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modified_ripemd128_hash
// Byte-serial RIPEMD-128 variant: gather, pad, compress, emit four words.
// ----------------------------------------------------------------------------
// channel | ports                              | direction
// in      | i_in_valid, o_in_stall, i_in_item  | byte, has_byte, last
// out     | o_out_valid, i_out_stall, o_out_item | digest word, index, last
//
// A byte item that does not close a block is written into the block buffer and the engine stays idle.
// Each block runs one compression step a cycle: 128 steps plus a fold;
// a last item adds one or two padded blocks and four words.
// The input queue takes up to DEPTH items while the engine is busy, then stalls.
// Reset is synchronous, active low, and restores the initial chaining words.
// ----------------------------------------------------------------------------
module modified_ripemd128_hash
    import mrh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    logic     q_valid, q_pop;
    t_in_item q_item;

    mrh_front #(.DEPTH(DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    mrh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

FILE: src/mrh_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrh_checker
// Port-level checks on the digest output sequence.
// ----------------------------------------------------------------------------
module mrh_checker
    import mrh_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.last_word == (o_out_item.word_index == 2'd3)))
        else $error("last_word out of step with word_index");

    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.last_word |=>
            o_out_valid && o_out_item.word_index == $past(o_out_item.word_index) + 2'd1)
        else $error("digest words not consecutive");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind modified_ripemd128_hash mrh_checker u_mrh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
`default_nettype wire

FILE: sim/modified_ripemd128_hash_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modified_ripemd128_hash_tb
// Self-checking bench: feeds byte streams of assorted lengths, with and
// without bytes on the closing item, and compares the four digest words of
// every message against a behavioural model of the modified hash.
// ----------------------------------------------------------------------------
module modified_ripemd128_hash_tb;
    import mrh_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    modified_ripemd128_hash u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    localparam logic [31:0] STEP_K [0:7] = '{32'h00000002, 32'h325b99a1, 32'h1baed69c,
        32'hbcdcb1f9, 32'h5a82798a, 32'h41d42d5d, 32'h30ed3f68, 32'h00000002};
    localparam logic [6:0] ODD_STEP [0:20] = '{17, 23, 25, 31, 43, 45, 50, 53, 57, 59,
        63, 70, 74, 78, 86, 87, 94, 102, 105, 110, 113};
    localparam logic [31:0] ODD_K [0:20] = '{32'h00000002, 32'hbcdcb1f9, 32'h00000002,
        32'h00000002, 32'h325b99a1, 32'hbcdcb1fa, 32'h325b99a1, 32'hbcdcb1fb,
        32'h1baed69c, 32'h00000002, 32'hbcdcb1fc, 32'h325b99a1, 32'hbcdcb1f9,
        32'hbcdcb1fc, 32'hbcdcb1f9, 32'hbcdcb1fd, 32'h325b99a1, 32'hbcdcb1fe,
        32'h5a82798a, 32'h41d42d5d, 32'hbcdcb1fe};
    localparam logic [1:0] ROUND_FN [0:7] = '{0, 1, 2, 3, 3, 2, 1, 0};

    logic [31:0]   chain [0:3];
    logic [7:0]    blk_bytes [0:63];
    logic [60:0]   msg_len;
    t_out_item     digest_q[$];
    int            n_errors;
    int            n_words;
    int            n_msgs;
    int            n_items;

    function automatic logic [31:0] rotl(logic [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] mix_fn(logic [1:0] f, logic [31:0] x,
                                           logic [31:0] y, logic [31:0] z);
        case (f)
            2'd0:    return x ^ y ^ z;
            2'd1:    return (x & y) | (~x & z);
            2'd2:    return (x | ~y) ^ z;
            default: return (x & z) | (y & ~z);
        endcase
    endfunction

    task automatic compress_block(input logic [7:0] b [0:63]);
        logic [31:0] w [0:15];
        logic [31:0] v [0:7];
        logic [31:0] k;
        logic [31:0] t;
        int base, la, rd;
        for (int i = 0; i < 16; i++)
            w[i] = {b[4*i+3], b[4*i+2], b[4*i+1], b[4*i]};
        for (int i = 0; i < 4; i++) begin
            v[i] = chain[i];
            v[i+4] = chain[i];
        end
        for (int s = 0; s < 128; s++) begin
            base = (s < 64) ? 0 : 4;
            la = (4 - (s % 4)) % 4;
            rd = s / 16;
            k = STEP_K[rd];
            for (int e = 0; e < 21; e++)
                if (ODD_STEP[e] == s) k = ODD_K[e];
            v[base+la] = rotl(v[base+la] + mix_fn(ROUND_FN[rd], v[base+(la+1)%4],
                v[base+(la+2)%4], v[base+(la+3)%4]) + w[K_WIDX[s]] + k, K_WROT[s]);
        end
        t = v[7] + v[2] + chain[1];
        chain[1] = chain[2] + v[3] + v[4];
        chain[2] = chain[3] + v[0] + v[5] + 32'd1;
        chain[3] = chain[0] + v[1] + v[6];
        chain[0] = t;
    endtask

    task automatic restart_message();
        chain[0] = IV0; chain[1] = IV1; chain[2] = IV2; chain[3] = IV3;
        msg_len = '0;
    endtask

    task automatic predict_digest(input t_in_item it);
        logic [7:0]  pad [0:63];
        logic [63:0] bits;
        int pos;
        t_out_item o;
        if (it.has_byte) begin
            blk_bytes[msg_len[5:0]] = it.data_byte;
            msg_len = msg_len + 1'b1;
            if (msg_len[5:0] == 0) compress_block(blk_bytes);
        end
        if (!it.last) return;
        pos = msg_len[5:0];
        bits = {msg_len, 3'b000};
        for (int i = 0; i < 64; i++) pad[i] = (i < pos) ? blk_bytes[i] : 8'h00;
        pad[pos] = PAD_BYTE;
        if (pos >= 56) begin
            compress_block(pad);
            for (int i = 0; i < 64; i++) pad[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) pad[56+i] = bits[8*i +: 8];
        compress_block(pad);
        for (int i = 0; i < 4; i++) begin
            o.digest_word = chain[i];
            o.word_index = 2'(i);
            o.last_word = (i == 3);
            digest_q.push_back(o);
        end
        n_msgs++;
        restart_message();
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic [7:0] d, input logic hb, input logic lst);
        t_in_item it;
        int g;
        it.data_byte = d; it.has_byte = hb; it.last = lst;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_digest(it);
        n_items++;
    endtask

    task automatic send_message(input int len, input logic close_with_byte);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom_range(0, 255)), 1'b1, close_with_byte && i == len - 1);
        if (!close_with_byte || len == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (digest_q.size() != 0);
    endtask

    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h5a, 1'b1, 1'b1);
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_pad_boundaries();
        send_message(64, 1'b1);
        send_message(56, 1'b1);
    endtask

    task automatic test_random_messages();
        int len;
        for (int m = 0; m < 4; m++) begin
            len = $urandom_range(0, 2);
            for (int i = 0; i < len; i++)
                send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) != 0), 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            if (m == 1) wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) i_out_stall <= ($urandom_range(0, 9) < 3) ||
                                    (n_words % 9 == 5 && $urandom_range(0, 1) == 1);
    end

    always @(posedge i_clk) begin
        t_out_item exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_words <= n_words + 1;
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word %h", $time, o_out_item);
                n_errors++;
            end else begin
                exp_w = digest_q.pop_front();
                if (o_out_item.digest_word !== exp_w.digest_word ||
                    o_out_item.word_index !== exp_w.word_index ||
                    o_out_item.last_word !== exp_w.last_word) begin
                    $display("%0t: digest mismatch exp %h/%0d/%0d got %h/%0d/%0d", $time,
                             exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                             o_out_item.digest_word, o_out_item.word_index,
                             o_out_item.last_word);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        n_errors = 0; n_words = 0; n_msgs = 0; n_items = 0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_item = '0; i_out_stall = 1'b0;
        restart_message();
        for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pad_boundaries();
        test_random_messages();
        wait_drained();
        repeat (400) @(posedge i_clk);
        $display("Sent %0d items in %0d messages, checked %0d digest words.",
                 n_items, n_msgs, n_words);
        if (n_errors == 0 && digest_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
